@@ src/twva_pkg.sv @@
`default_nettype none

package twva_pkg;

    localparam int TIME_W  = 48;
    localparam int COORD_W = 32;
    localparam int COUNT_W = 9;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 48'd5000000;

    // One input word: the current time and an optional timestamped sample.
    typedef struct packed {
        logic [TIME_W-1:0]         current_time;
        logic                      sample_present;
        logic [TIME_W-1:0]         sample_time;
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic signed [COORD_W-1:0] sample_z;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic                      average_valid;
        logic signed [COORD_W-1:0] mean_x;
        logic signed [COORD_W-1:0] mean_y;
        logic signed [COORD_W-1:0] mean_z;
        logic [COUNT_W-1:0]        sample_count;
        logic                      overflow_seen;
    } out_word_t;

    // One entry of the sample ring.
    typedef struct packed {
        logic [TIME_W-1:0]         stamp;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } entry_t;

endpackage

`default_nettype wire

@@ src/twva_ram.sv @@
`default_nettype none

module twva_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/twva_div.sv @@
`default_nettype none

module twva_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 9
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [NUM_W-1:0]  numer,
    input  wire logic [DEN_W-1:0]         denom,
    output logic                          busy,
    output logic signed [twva_pkg::COORD_W-1:0] quotient
);

    import twva_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  mag_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;

    logic [NUM_W-1:0] numer_u;
    logic [NUM_W-1:0] numer_abs;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign numer_u   = numer;
    assign numer_abs = numer_u[NUM_W-1] ? (~numer_u + 1'b1) : numer_u;

    // Restoring division, one quotient bit per cycle. The quotient bits
    // shift into the low end of the magnitude register.
    assign trial = {rem_reg, mag_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && step_reg == STEP_W'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= STEP_W'(NUM_W);
            mag_reg  <= numer_abs;
            rem_reg  <= '0;
            den_reg  <= denom;
            neg_reg  <= numer_u[NUM_W-1];
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            mag_reg  <= {mag_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -mag_reg[COORD_W-1:0] : mag_reg[COORD_W-1:0];

endmodule

`default_nettype wire

@@ src/time_window_vector_average_core.sv @@
// Channel   Direction  Ports                           Moves
// s_        in         s_valid, s_ready, s_data        one time word, optional sample
// m_        out        m_valid, m_ready, m_data        one average word per input word
// cfg_      in         cfg_valid, cfg_ready, cfg_data  window length in microseconds
//
// One word is worked on at a time: its sample is appended (a full ring first drops its
// oldest sample), samples are evicted by age, the entry that stays is checked, the three
// axes are divided side by side by bit-serial division, and the result is handed over. A
// word that empties the ring skips the division.
// Reset is synchronous and active low; the ring needs no clearing pass.
// A result that waits on m_ready only stalls the block at its last step.
`default_nettype none

module time_window_vector_average_core #(
    parameter int WINDOW_DEPTH = 256
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire twva_pkg::in_word_t         s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output twva_pkg::out_word_t             m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [twva_pkg::TIME_W-1:0] cfg_data
);

    import twva_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    // Wide enough for the exact sum of a full ring of 32-bit samples.
    localparam int SUM_W = COORD_W + PTR_W;
    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DROP   = 7'b0000010,
        S_APPEND = 7'b0000100,
        S_EV_RD  = 7'b0001000,
        S_EV_CHK = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    in_word_t item_reg, item_next;
    logic [TIME_W-1:0] bound_reg, bound_next;
    logic [TIME_W-1:0] window_length_reg;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic signed [SUM_W-1:0] sum_z_reg, sum_z_next;
    logic overflow_reg, overflow_next;
    out_word_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;

    // Ring memory.
    logic             ram_we;
    logic             ram_re;
    logic [PTR_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;

    // Dividers.
    logic                      div_start;
    logic [2:0]                div_busy;
    logic signed [COORD_W-1:0] quo_x;
    logic signed [COORD_W-1:0] quo_y;
    logic signed [COORD_W-1:0] quo_z;

    logic [CNT_W:0]          wr_sum;
    logic [PTR_W-1:0]        ptr_inc;
    logic [TIME_W-1:0]       bound_calc;
    logic signed [SUM_W-1:0] add_x, add_y, add_z;
    logic signed [SUM_W-1:0] old_x, old_y, old_z;
    logic                    s_accept;

    twva_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ptr_reg),
        .rdata(ram_rdata)
    );

    twva_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .numer(sum_x_reg),
        .denom(count_reg), .busy(div_busy[0]), .quotient(quo_x)
    );

    twva_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .numer(sum_y_reg),
        .denom(count_reg), .busy(div_busy[1]), .quotient(quo_y)
    );

    twva_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_z (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .numer(sum_z_reg),
        .denom(count_reg), .busy(div_busy[2]), .quotient(quo_z)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // The write slot is the entry just past the newest sample. Appends only
    // happen with the ring below full, so one conditional subtract wraps it.
    assign wr_sum    = (CNT_W+1)'(ptr_reg) + (CNT_W+1)'(count_reg);
    assign ram_waddr = (wr_sum >= (CNT_W+1)'(WINDOW_DEPTH))
                     ? PTR_W'(wr_sum - (CNT_W+1)'(WINDOW_DEPTH))
                     : PTR_W'(wr_sum);
    assign ram_wdata = '{stamp: item_reg.sample_time, x: item_reg.sample_x,
                         y: item_reg.sample_y, z: item_reg.sample_z};

    assign ptr_inc = (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    // Samples stamped before this bound are stale; the bound stops at zero.
    assign bound_calc = (s_data.current_time > window_length_reg)
                      ? s_data.current_time - window_length_reg : '0;

    assign add_x = {{(SUM_W-COORD_W){item_reg.sample_x[COORD_W-1]}}, item_reg.sample_x};
    assign add_y = {{(SUM_W-COORD_W){item_reg.sample_y[COORD_W-1]}}, item_reg.sample_y};
    assign add_z = {{(SUM_W-COORD_W){item_reg.sample_z[COORD_W-1]}}, item_reg.sample_z};
    assign old_x = {{(SUM_W-COORD_W){ram_rdata.x[COORD_W-1]}}, ram_rdata.x};
    assign old_y = {{(SUM_W-COORD_W){ram_rdata.y[COORD_W-1]}}, ram_rdata.y};
    assign old_z = {{(SUM_W-COORD_W){ram_rdata.z[COORD_W-1]}}, ram_rdata.z};

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        bound_next    = bound_reg;
        ptr_next      = ptr_reg;
        count_next    = count_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        sum_z_next    = sum_z_reg;
        overflow_next = overflow_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        div_start     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    item_next     = s_data;
                    bound_next    = bound_calc;
                    overflow_next = 1'b0;
                    if (s_data.sample_present && count_reg == CNT_W'(WINDOW_DEPTH)) begin
                        // Full ring: fetch the oldest sample so it can leave the sums.
                        ram_re     = 1'b1;
                        state_next = S_DROP;
                    end else if (s_data.sample_present) begin
                        state_next = S_APPEND;
                    end else begin
                        state_next = S_EV_RD;
                    end
                end
            end
            S_DROP: begin
                sum_x_next    = sum_x_reg - old_x;
                sum_y_next    = sum_y_reg - old_y;
                sum_z_next    = sum_z_reg - old_z;
                ptr_next      = ptr_inc;
                count_next    = count_reg - 1'b1;
                overflow_next = 1'b1;
                state_next    = S_APPEND;
            end
            S_APPEND: begin
                ram_we     = 1'b1;
                sum_x_next = sum_x_reg + add_x;
                sum_y_next = sum_y_reg + add_y;
                sum_z_next = sum_z_reg + add_z;
                count_next = count_reg + 1'b1;
                state_next = S_EV_RD;
            end
            S_EV_RD: begin
                // The append wrote the ring in an earlier state, so the read here
                // always sees it.
                if (count_reg == '0) begin
                    state_next = S_FINISH;
                end else begin
                    ram_re     = 1'b1;
                    state_next = S_EV_CHK;
                end
            end
            S_EV_CHK: begin
                if (ram_rdata.stamp < bound_reg) begin
                    sum_x_next = sum_x_reg - old_x;
                    sum_y_next = sum_y_reg - old_y;
                    sum_z_next = sum_z_reg - old_z;
                    ptr_next   = ptr_inc;
                    count_next = count_reg - 1'b1;
                    state_next = S_EV_RD;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_busy == '0) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    out_next.average_valid = (count_reg != '0);
                    out_next.mean_x        = (count_reg != '0) ? quo_x : '0;
                    out_next.mean_y        = (count_reg != '0) ? quo_y : '0;
                    out_next.mean_z        = (count_reg != '0) ? quo_z : '0;
                    out_next.sample_count  = COUNT_W'(count_reg);
                    out_next.overflow_seen = overflow_reg;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            ptr_reg           <= '0;
            count_reg         <= '0;
            sum_x_reg         <= '0;
            sum_y_reg         <= '0;
            sum_z_reg         <= '0;
            m_valid_reg       <= 1'b0;
            window_length_reg <= WINDOW_RESET;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            sum_z_reg   <= sum_z_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                window_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        bound_reg    <= bound_next;
        overflow_reg <= overflow_next;
        out_reg      <= out_next;
    end

endmodule

`default_nettype wire

@@ src/twva_checker.sv @@
`default_nettype none

module twva_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire twva_pkg::out_word_t m_data
);

    import twva_pkg::*;

    // Words taken in but not yet delivered.
    logic [1:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_valid && s_ready) - 2'(m_valid && m_ready);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result word without a matching input word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more than two words in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.average_valid |->
            m_data.sample_count == '0 && m_data.mean_x == '0 &&
            m_data.mean_y == '0 && m_data.mean_z == '0)
        else $error("empty window reported nonzero mean or count");

endmodule

bind time_window_vector_average_core twva_checker u_twva_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

// Checks time_window_vector_average_core against a predictor of the
// moving average. Input words come from a queue that the stimulus process
// fills. The driver offers them on the s_ channel, and the monitor checks
// every m_ word against the oldest expected average.
module testbench;
    import twva_pkg::*;

    localparam int RING_DEPTH       = 256;
    localparam int LONG_HOLD_CYCLES = 2000;
    localparam int SETTLE_CYCLES    = 120;
    localparam int RUN_LIMIT_NS     = 60_000_000;
    localparam int MAX_PRINTED      = 40;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_word_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_word_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TIME_W-1:0]   cfg_data  = '0;

    time_window_vector_average_core #(
        .WINDOW_DEPTH(RING_DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Words waiting to be offered, and averages waiting to come out.
    in_word_t  pending_words[$];
    out_word_t expected_averages[$];

    // Idling controls, in percent of cycles. The stimulus process changes
    // them only between phases.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_request   = 1'b0;
    logic hold_off       = 1'b0;
    logic s_taken        = 1'b0;
    int   mismatch_count = 0;

    // The predictor's copy of the ring, the running sums and the window
    // length register.
    logic [TIME_W-1:0] ring_stamp [RING_DEPTH];
    int                ring_x [RING_DEPTH];
    int                ring_y [RING_DEPTH];
    int                ring_z [RING_DEPTH];
    int                ring_head  = 0;
    int                ring_fill  = 0;
    longint            total_x    = 0;
    longint            total_y    = 0;
    longint            total_z    = 0;
    logic [TIME_W-1:0] window_len = WINDOW_RESET;

    // Time base of the well-formed random sequences.
    logic [TIME_W-1:0] clock_now = 48'd10_000_000;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The oldest sample leaves the ring and the sums.
    function automatic void drop_oldest_sample();
        total_x   -= ring_x[ring_head];
        total_y   -= ring_y[ring_head];
        total_z   -= ring_z[ring_head];
        ring_head  = (ring_head + 1) % RING_DEPTH;
        ring_fill--;
    endfunction

    // Works out the average word that one accepted input word produces and
    // moves the predictor state along with it.
    function automatic out_word_t predict_average(input in_word_t w);
        out_word_t         r;
        logic [TIME_W-1:0] bound;
        int                slot;
        r = '0;
        if (w.sample_present) begin
            // A full ring makes room by dropping its oldest sample first.
            if (ring_fill >= RING_DEPTH) begin
                drop_oldest_sample();
                r.overflow_seen = 1'b1;
            end
            slot = (ring_head + ring_fill) % RING_DEPTH;
            ring_stamp[slot] = w.sample_time;
            ring_x[slot]     = w.sample_x;
            ring_y[slot]     = w.sample_y;
            ring_z[slot]     = w.sample_z;
            total_x += ring_x[slot];
            total_y += ring_y[slot];
            total_z += ring_z[slot];
            ring_fill++;
        end
        // The bound saturates at zero when the window reaches back past time zero.
        bound = (w.current_time > window_len) ? w.current_time - window_len : '0;
        // The walk stops at the first sample that is recent enough, so stale
        // samples further back in the ring stay until they reach the front.
        while (ring_fill > 0 && ring_stamp[ring_head] < bound) begin
            drop_oldest_sample();
        end
        if (ring_fill > 0) begin
            // Signed division in SystemVerilog truncates toward zero.
            r.average_valid = 1'b1;
            r.mean_x        = 32'(total_x / ring_fill);
            r.mean_y        = 32'(total_y / ring_fill);
            r.mean_z        = 32'(total_z / ring_fill);
            r.sample_count  = COUNT_W'(ring_fill);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    function automatic logic [TIME_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Half of the coordinates span the full range, the rest stay near zero so
    // that means of mixed signs show the truncation.
    function automatic logic [COORD_W-1:0] rand_coord();
        if ($urandom_range(1) == 0) begin
            return $urandom;
        end
        return 32'($urandom_range(2000)) - 32'd1000;
    endfunction

    task automatic push_word(input logic [TIME_W-1:0] now, input logic present,
                             input logic [TIME_W-1:0] stamp, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
        in_word_t w;
        w.current_time   = now;
        w.sample_present = present;
        w.sample_time    = stamp;
        w.sample_x       = x;
        w.sample_y       = y;
        w.sample_z       = z;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Most words follow a rising clock with samples stamped near it. One in
    // ten samples is stamped older than the window, and a share of the words
    // is noise with every field random.
    task automatic queue_random_words(input int count, input int present_pct,
                                      input int step_max, input int noise_pct);
        logic [TIME_W-1:0] stamp;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < noise_pct) begin
                push_word(rand48(), 1'($urandom), rand48(), $urandom, $urandom, $urandom);
            end else begin
                clock_now = clock_now + $urandom_range(step_max);
                if ($urandom_range(9) == 0) begin
                    stamp = clock_now - window_len - 1 - $urandom_range(step_max);
                end else begin
                    stamp = clock_now + $urandom_range(step_max) - $urandom_range(step_max);
                end
                push_word(clock_now, $urandom_range(99) < present_pct, stamp,
                          rand_coord(), rand_coord(), rand_coord());
            end
        end
    endtask

    // Returns once every queued word has been accepted and every expected
    // average has come out. Polled at the rising edge, where the queue and
    // s_valid are stable.
    task automatic wait_for_results();
        do begin
            @(posedge aclk);
        end while (pending_words.size() != 0 || s_valid || expected_averages.size() != 0);
    endtask

    // Writes the window length while the block is idle.
    task automatic write_window(input logic [TIME_W-1:0] length);
        @(negedge aclk);
        cfg_data  <= length;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        window_len = length;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sender: a word stays on the channel until it is taken, and only then
    // may the next one or an idle cycle follow.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= pending_words[0];
                s_valid <= 1'b1;
                pending_words.delete(0);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off when it is active.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The long hold-off runs in its own process. While it lasts, the sender
    // keeps offering words, so the block fills and stops taking input.
    initial begin
        wait (hold_request);
        hold_off = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Monitor: predicts on every accepted input word and checks every
    // accepted result word against the oldest expectation, field by field.
    always @(posedge aclk) begin
        out_word_t want;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_averages.insert(expected_averages.size(), predict_average(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_averages.size() == 0) begin
                    report_mismatch("unrequested word", 64'(m_data), '0);
                end else begin
                    want = expected_averages[0];
                    expected_averages.delete(0);
                    if (m_data.average_valid !== want.average_valid) begin
                        report_mismatch("average_valid", 64'(m_data.average_valid),
                                        64'(want.average_valid));
                    end
                    if (m_data.mean_x !== want.mean_x) begin
                        report_mismatch("mean_x", 64'(m_data.mean_x), 64'(want.mean_x));
                    end
                    if (m_data.mean_y !== want.mean_y) begin
                        report_mismatch("mean_y", 64'(m_data.mean_y), 64'(want.mean_y));
                    end
                    if (m_data.mean_z !== want.mean_z) begin
                        report_mismatch("mean_z", 64'(m_data.mean_z), 64'(want.mean_z));
                    end
                    if (m_data.sample_count !== want.sample_count) begin
                        report_mismatch("sample_count", 64'(m_data.sample_count),
                                        64'(want.sample_count));
                    end
                    if (m_data.overflow_seen !== want.overflow_seen) begin
                        report_mismatch("overflow_seen", 64'(m_data.overflow_seen),
                                        64'(want.overflow_seen));
                    end
                end
            end
        end
    end

    // Stimulus, phase by phase.
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset window of five seconds. The first
        // finds the ring empty, and its sample fields are ignored.
        push_word(48'd0, 1'b0, '1, '1, '1, '1);
        // Extreme coordinates; the sums grow past 32 bits.
        push_word(48'd1000, 1'b1, 48'd1000, 32'h7FFF_FFFF, 32'h8000_0000, -3);
        push_word(48'd2000, 1'b1, 48'd2000, 32'h7FFF_FFFF, 32'h8000_0000, 2);
        // A sample stamped in the future, then a stale one behind it.
        push_word(48'd3000, 1'b1, 48'd3_000_000, -7, 7, 0);
        push_word(48'd4000, 1'b1, 48'd500, 1, -1, -1);
        // Eviction stops at the future sample; the stale one stays behind it.
        push_word(48'd6_000_000, 1'b0, 48'd0, 0, 0, 0);
        // Now the stale sample reaches the front and leaves as well.
        push_word(48'd8_100_000, 1'b1, 48'd8_100_000, 5, -5, 9);
        // A sample older than the bound is appended and evicted in the same word.
        push_word(48'd20_000_000, 1'b1, 48'd0, 11, 12, 13);
        // Largest times.
        push_word('1, 1'b1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_word('1, 1'b1, 48'hFFFF_FFB3_B4BE, -1, -1, -1);
        push_word('1, 1'b0, '1, '1, '1, '1);
        // Window longer than the current time: the bound is zero.
        push_word(48'd0, 1'b1, 48'd0, 0, 0, 0);
        push_word(48'd5_000_000, 1'b1, 48'd0, 3, -3, 1);
        push_word(48'd5_000_001, 1'b0, 48'd0, 0, 0, 0);
        wait_for_results();

        write_window('0);
        push_word(48'h8000_0000_0000, 1'b1, 48'h8000_0000_0000, 4, -4, 8);
        push_word(48'h8000_0000_0001, 1'b1, 48'h8000_0000_0001, -9, 9, 0);
        wait_for_results();

        // Largest window: nothing ages out, so the ring fills and overflows.
        // The sender pauses halfway until every average has come out, and
        // the second half runs under the long receiver hold-off.
        write_window('1);
        queue_random_words(140, 97, 1000, 0);
        wait_for_results();
        hold_request = 1'b1;
        queue_random_words(140, 97, 1000, 0);
        wait_for_results();

        // Zero window: the first word evicts the stale front of a full ring, and
        // afterwards only samples at or after the current time survive at the front.
        write_window('0);
        send_idle_pct = 87;
        queue_random_words(60, 80, 50, 5);
        wait_for_results();

        write_window(48'(10_000 + $urandom_range(40_000)));
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        queue_random_words(120, 85, 2000, 5);
        wait_for_results();

        write_window(48'd5000);
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        queue_random_words(120, 85, 1000, 5);
        wait_for_results();

        // A random window of random size, with plenty of noise.
        write_window(rand48() >> $urandom_range(47));
        queue_random_words(50, 70, 1 << 20, 30);
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_averages.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
